### rtl/markup_tag_balance_checker_unit_macros.svh
// Assertion macros for the markup tag balance checker.
`ifndef MARKUP_TAG_BALANCE_CHECKER_UNIT_MACROS_SVH
`define MARKUP_TAG_BALANCE_CHECKER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check cons in the same cycle whenever ante holds.
`define MTB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check cons in the cycle after ante holds.
`define MTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTB_ASSERT_NOW(label, ante, cons, msg)
`define MTB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### rtl/mtb_pkg.sv
// Shared types and character codes of the markup tag balance checker.
`default_nettype none
package mtb_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_H     = 8'h68;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic name_we;
    logic len_we;
  } mem_cmd_t;

endpackage
`default_nettype wire

### rtl/markup_tag_balance_checker_unit.sv
// Top level of the markup tag balance checker.
// Takes one text byte per transaction and, on the byte flagged end_of_line, returns one
// verdict: is_correct when every tag closed in order with no limit exceeded, and
// overflow_seen when the stack depth or tag length limit was hit. In the accept cycle the
// stack-top name byte and the length below the top are read from their memories; in the
// work state that follows, the byte is compared, written into the free slot above the top
// and the stack pointer is updated. Tag names are compared byte by byte as they arrive, so
// '>' needs no separate compare pass. The verdict sits in an output register; a new byte
// is accepted while it waits, and only a following end_of_line byte holds until it is
// taken. No clearing pass is needed after reset.
`default_nettype none
`include "markup_tag_balance_checker_unit_macros.svh"
module markup_tag_balance_checker_unit #(
  parameter int MAX_TAG_LEN = 32,
  parameter int STACK_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_line,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       is_correct,
  output      logic       overflow_seen
);
  import mtb_pkg::*;

  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int IW = $clog2(MAX_TAG_LEN);
  localparam int TW = $clog2(MAX_TAG_LEN + 1);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  mem_cmd_t          mem_cmd;
  logic [SW+IW-1:0]  name_raddr;
  logic [SW+IW-1:0]  name_waddr;
  logic [7:0]        name_wdata;
  logic [7:0]        name_rdata;
  logic [SW-1:0]     len_raddr;
  logic [SW-1:0]     len_waddr;
  logic [TW-1:0]     len_wdata;
  logic [TW-1:0]     len_rdata;
  logic [CW-1:0]     depth;

  mtb_ctrl #(
    .MAX_TAG_LEN(MAX_TAG_LEN),
    .STACK_DEPTH(STACK_DEPTH),
    .SW(SW),
    .IW(IW),
    .TW(TW),
    .CW(CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .end_of_line  (end_of_line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_correct   (is_correct),
    .overflow_seen(overflow_seen),
    .mem_cmd      (mem_cmd),
    .name_raddr   (name_raddr),
    .name_waddr   (name_waddr),
    .name_wdata   (name_wdata),
    .name_rdata   (name_rdata),
    .len_raddr    (len_raddr),
    .len_waddr    (len_waddr),
    .len_wdata    (len_wdata),
    .len_rdata    (len_rdata),
    .depth        (depth)
  );

  mtb_stack_store #(
    .SW(SW),
    .IW(IW),
    .TW(TW)
  ) u_store (
    .clk       (clk),
    .mem_cmd   (mem_cmd),
    .name_raddr(name_raddr),
    .name_waddr(name_waddr),
    .name_wdata(name_wdata),
    .name_rdata(name_rdata),
    .len_raddr (len_raddr),
    .len_waddr (len_waddr),
    .len_wdata (len_wdata),
    .len_rdata (len_rdata)
  );

  `MTB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted back to back")
  `MTB_ASSERT_NOW(a_depth_bound, 1'b1, depth <= CW'(STACK_DEPTH), "stack depth out of range")
  `MTB_ASSERT_NOW(a_write_when_busy, mem_cmd.name_we || mem_cmd.len_we, in_stall, "idle write")
  `MTB_ASSERT_NOW(a_no_rd_wr_overlap, mem_cmd.rd_en, !mem_cmd.name_we && !mem_cmd.len_we,
                  "read and write in one cycle")

endmodule
`default_nettype wire

### rtl/mtb_stack_store.sv
// Name stack storage: byte memory of stacked names and memory of their lengths.
`default_nettype none
module mtb_stack_store #(
  parameter int SW = 6,
  parameter int IW = 5,
  parameter int TW = 6
) (
  input  wire logic              clk,
  input  wire mtb_pkg::mem_cmd_t mem_cmd,
  input  wire logic [SW+IW-1:0]  name_raddr,
  input  wire logic [SW+IW-1:0]  name_waddr,
  input  wire logic [7:0]        name_wdata,
  output      logic [7:0]        name_rdata,
  input  wire logic [SW-1:0]     len_raddr,
  input  wire logic [SW-1:0]     len_waddr,
  input  wire logic [TW-1:0]     len_wdata,
  output      logic [TW-1:0]     len_rdata
);
  import mtb_pkg::*;

  logic [7:0]    name_mem [2**(SW+IW)];
  logic [TW-1:0] len_mem  [2**SW];

  always_ff @(posedge clk) begin
    if (mem_cmd.name_we) begin
      name_mem[name_waddr] <= name_wdata;
    end
    if (mem_cmd.rd_en) begin
      name_rdata <= name_mem[name_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_cmd.len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (mem_cmd.rd_en) begin
      len_rdata <= len_mem[len_raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/mtb_ctrl.sv
// Sequencer: character decode, running compare against the stack top, verdict register.
`default_nettype none
module mtb_ctrl #(
  parameter int MAX_TAG_LEN = 32,
  parameter int STACK_DEPTH = 64,
  parameter int SW = 6,
  parameter int IW = 5,
  parameter int TW = 6,
  parameter int CW = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [7:0]        char_code,
  input  wire logic              end_of_line,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic              is_correct,
  output      logic              overflow_seen,
  output      mtb_pkg::mem_cmd_t mem_cmd,
  output      logic [SW+IW-1:0]  name_raddr,
  output      logic [SW+IW-1:0]  name_waddr,
  output      logic [7:0]        name_wdata,
  input  wire logic [7:0]        name_rdata,
  output      logic [SW-1:0]     len_raddr,
  output      logic [SW-1:0]     len_waddr,
  output      logic [TW-1:0]     len_wdata,
  input  wire logic [TW-1:0]     len_rdata,
  output      logic [CW-1:0]     depth
);
  import mtb_pkg::*;

  state_t        state, state_next;
  logic [7:0]    ch, ch_next;
  logic          eol, eol_next;
  logic [CW-1:0] sc, sc_next;
  logic [TW-1:0] tl, tl_next;
  logic [TW-1:0] top_len, top_len_next;
  logic          in_tag, in_tag_next;
  logic          mm, mm_next;
  logic          ov, ov_next;
  logic          match, match_next;
  logic [7:0]    c0, c0_next;
  logic [7:0]    c1, c1_next;
  logic          out_valid_next;
  logic          is_correct_next;
  logic          overflow_seen_next;

  logic accept;
  logic hold;
  logic has_room;
  logic ignore;
  logic closes;
  logic do_push;

  assign depth    = sc;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign has_room = (sc < CW'(STACK_DEPTH));
  assign hold     = eol && out_valid && out_stall;

  assign ignore = (tl == TW'(2)) && (c1 == CH_R) && ((c0 == CH_B) || (c0 == CH_H));
  assign closes = (sc != '0) && match &&
                  (({1'b0, top_len} + (TW+1)'(1)) == {1'b0, tl});

  // Reads of the stack-top byte and of the length below the top go out with the accept.
  assign name_raddr = {SW'(sc - CW'(1)), IW'(tl - TW'(1))};
  assign len_raddr  = SW'(sc - CW'(2));
  assign name_waddr = {SW'(sc), IW'(tl)};
  assign name_wdata = ch;
  assign len_waddr  = SW'(sc);
  assign len_wdata  = tl;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    ch_next            = ch;
    eol_next           = eol;
    sc_next            = sc;
    tl_next            = tl;
    top_len_next       = top_len;
    in_tag_next        = in_tag;
    mm_next            = mm;
    ov_next            = ov;
    match_next         = match;
    c0_next            = c0;
    c1_next            = c1;
    out_valid_next     = out_valid && out_stall;
    is_correct_next    = is_correct;
    overflow_seen_next = overflow_seen;
    do_push            = 1'b0;
    mem_cmd            = '0;
    mem_cmd.rd_en      = accept;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          ch_next    = char_code;
          eol_next   = end_of_line;
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        if (!hold) begin
          state_next = ST_IDLE;
          if (ch == CH_OPEN) begin
            in_tag_next = 1'b1;
          end else if (ch == CH_CLOSE) begin
            if (!ignore) begin
              if ((tl == '0) || (c0 != CH_SLASH)) begin
                do_push = 1'b1;
              end else if (closes) begin
                sc_next      = sc - CW'(1);
                mm_next      = 1'b0;
                top_len_next = len_rdata;
              end else begin
                do_push = 1'b1;
                mm_next = 1'b1;
              end
            end
            if (do_push) begin
              if (has_room) begin
                mem_cmd.len_we = 1'b1;
                sc_next        = sc + CW'(1);
                top_len_next   = tl;
              end else begin
                ov_next = 1'b1;
              end
            end
            tl_next     = '0;
            in_tag_next = 1'b0;
            match_next  = 1'b1;
          end else if (in_tag) begin
            if (tl < TW'(MAX_TAG_LEN)) begin
              // Write the byte straight into the free slot above the top, if the stack has room.
              mem_cmd.name_we = has_room;
              if (tl == TW'(0)) begin
                c0_next = ch;
              end
              if (tl == TW'(1)) begin
                c1_next = ch;
              end
              if ((tl != '0) && (tl <= top_len)) begin
                match_next = match && (name_rdata == ch);
              end
              tl_next = tl + TW'(1);
            end else begin
              ov_next = 1'b1;
            end
          end
          if (eol) begin
            out_valid_next     = 1'b1;
            is_correct_next    = (sc_next == '0) && !mm_next && !ov_next;
            overflow_seen_next = ov_next;
            sc_next            = '0;
            tl_next            = '0;
            top_len_next       = '0;
            in_tag_next        = 1'b0;
            mm_next            = 1'b0;
            ov_next            = 1'b0;
            match_next         = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc        <= '0;
      tl        <= '0;
      top_len   <= '0;
      in_tag    <= 1'b0;
      mm        <= 1'b0;
      ov        <= 1'b0;
      match     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      sc        <= sc_next;
      tl        <= tl_next;
      top_len   <= top_len_next;
      in_tag    <= in_tag_next;
      mm        <= mm_next;
      ov        <= ov_next;
      match     <= match_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ch            <= ch_next;
    eol           <= eol_next;
    c0            <= c0_next;
    c1            <= c1_next;
    is_correct    <= is_correct_next;
    overflow_seen <= overflow_seen_next;
  end

endmodule
`default_nettype wire

### verif/markup_tag_balance_checker_unit_test.sv
// Self-checking testbench for the markup tag balance checker unit.
`timescale 1ns / 100ps
module markup_tag_balance_checker_unit_test;
  import mtb_pkg::*;

  localparam int MAX_TAG_LEN = 32;
  localparam int STACK_DEPTH = 64;
  localparam int RANDOM_CHARS = 1100;
  localparam int HOLD_AT = 120;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_FROM = 2000;
  localparam int QUIET_TO = 3000;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } text_byte_t;

  typedef struct packed {
    logic ok;
    logic ovf;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_code = 8'h00;
  logic       end_of_line = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       is_correct;
  logic       overflow_seen;

  markup_tag_balance_checker_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_code(char_code),
    .end_of_line(end_of_line),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_correct(is_correct),
    .overflow_seen(overflow_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_byte_t text_bytes[$];
  logic [7:0] line_buf[$];
  verdict_t   verdicts_due[$];
  text_byte_t next_byte;
  verdict_t   want;
  int         random_chars = 0;
  int         accepted_chars = 0;
  int         cycles = 0;
  int         mismatches = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  bit         in_took = 1'b0;

  // Tag stack tracking state.
  logic [7:0] stk_name[STACK_DEPTH][MAX_TAG_LEN];
  int         stk_len[STACK_DEPTH];
  int         stk_cnt = 0;
  logic [7:0] tag_buf[MAX_TAG_LEN];
  int         tag_len = 0;
  bit         in_tag = 1'b0;
  bit         unmatched = 1'b0;
  bit         overflowed = 1'b0;

  function automatic void push_name();
    if (stk_cnt >= STACK_DEPTH) begin
      overflowed = 1'b1;
    end else begin
      for (int i = 0; i < tag_len; i++) stk_name[stk_cnt][i] = tag_buf[i];
      stk_len[stk_cnt] = tag_len;
      stk_cnt++;
    end
  endfunction

  function automatic bit closes_top();
    int t;
    bit same;
    if (stk_cnt == 0) return 1'b0;
    t = stk_cnt - 1;
    if (tag_len != stk_len[t] + 1) return 1'b0;
    same = 1'b1;
    for (int i = 0; i < stk_len[t]; i++)
      if (tag_buf[i + 1] != stk_name[t][i]) same = 1'b0;
    return same;
  endfunction

  function automatic void close_tag();
    bit skip;
    skip = tag_len == 2 && tag_buf[1] == CH_R && (tag_buf[0] == CH_B || tag_buf[0] == CH_H);
    if (!skip) begin
      if (tag_len == 0 || tag_buf[0] != CH_SLASH) begin
        push_name();
      end else if (closes_top()) begin
        stk_cnt--;
        unmatched = 1'b0;
      end else begin
        push_name();
        unmatched = 1'b1;
      end
    end
  endfunction

  function automatic void track_char(logic [7:0] c, logic eol);
    verdict_t v;
    if (c == CH_OPEN) begin
      in_tag = 1'b1;
    end else if (c == CH_CLOSE) begin
      close_tag();
      tag_len = 0;
      in_tag = 1'b0;
    end else if (in_tag) begin
      if (tag_len < MAX_TAG_LEN) begin
        tag_buf[tag_len] = c;
        tag_len++;
      end else begin
        overflowed = 1'b1;
      end
    end
    if (eol) begin
      v.ok = stk_cnt == 0 && !unmatched && !overflowed;
      v.ovf = overflowed;
      verdicts_due.push_back(v);
      stk_cnt = 0;
      tag_len = 0;
      in_tag = 1'b0;
      unmatched = 1'b0;
      overflowed = 1'b0;
    end
  endfunction

  task automatic note_mismatch(string what, logic e, logic a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s at cycle %0d: expected %0b, got %0b", what, cycles, e, a);
  endtask

  // Queue the collected line, flagging its last byte.
  task automatic emit_line();
    text_byte_t tb;
    for (int i = 0; i < line_buf.size(); i++) begin
      tb.ch = line_buf[i];
      tb.eol = i == line_buf.size() - 1;
      text_bytes.push_back(tb);
    end
    random_chars += line_buf.size();
    line_buf.delete();
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    emit_line();
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CH_OPEN || b == CH_CLOSE || b == CH_SLASH) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    if ($urandom_range(3) == 0) b = plain_byte();
    else b = 8'($urandom_range(8'h61, 8'h65));
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    case ($urandom_range(7))
      0: b = CH_OPEN;
      1: b = CH_CLOSE;
      2: b = CH_SLASH;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // Opening tags with random names, then closing tags in reverse, mostly intact.
  task automatic add_nested_line();
    logic [7:0] nm[6][MAX_TAG_LEN];
    int ln[6];
    int depth;
    int r;
    int pos;
    depth = $urandom_range(1, 6);
    for (int k = 0; k < depth; k++) begin
      repeat ($urandom_range(0, 2)) line_buf.push_back(plain_byte());
      if ($urandom_range(9) == 0) begin
        line_buf.push_back(CH_OPEN);
        line_buf.push_back($urandom_range(1) ? CH_B : CH_H);
        line_buf.push_back(CH_R);
        line_buf.push_back(CH_CLOSE);
      end
      r = $urandom_range(19);
      ln[k] = (r == 0) ? MAX_TAG_LEN - 1 : (r == 1) ? MAX_TAG_LEN : $urandom_range(0, 4);
      line_buf.push_back(CH_OPEN);
      for (int i = 0; i < ln[k]; i++) begin
        nm[k][i] = (i == 0 || $urandom_range(15) != 0) ? name_byte() : CH_SLASH;
        line_buf.push_back(nm[k][i]);
      end
      line_buf.push_back(CH_CLOSE);
    end
    for (int k = depth - 1; k >= 0; k--) begin
      r = $urandom_range(9);
      if (r != 0) begin
        line_buf.push_back(CH_OPEN);
        line_buf.push_back(CH_SLASH);
        if (r == 1 && ln[k] > 0) begin
          pos = $urandom_range(ln[k] - 1);
          nm[k][pos] = nm[k][pos] ^ (8'h01 << $urandom_range(7));
        end
        for (int i = 0; i < ln[k]; i++) line_buf.push_back(nm[k][i]);
        if (r == 2) line_buf.push_back(name_byte());
        line_buf.push_back(CH_CLOSE);
      end
    end
    if ($urandom_range(9) == 0) begin
      line_buf.push_back(CH_OPEN);
      line_buf.push_back(CH_SLASH);
      line_buf.push_back(name_byte());
      line_buf.push_back(CH_CLOSE);
    end
    emit_line();
  endtask

  task automatic add_overlong_line();
    line_buf.push_back(CH_OPEN);
    repeat ($urandom_range(MAX_TAG_LEN + 1, MAX_TAG_LEN + 8)) line_buf.push_back(name_byte());
    if ($urandom_range(1)) line_buf.push_back(CH_CLOSE);
    emit_line();
  endtask

  task automatic add_noise_line();
    repeat ($urandom_range(1, 12)) line_buf.push_back(noise_byte());
    emit_line();
  endtask

  // Stray '>' pushes an empty name and "</>" pops one: a cheap way to fill the stack.
  task automatic add_stack_line(int pushes, bit close_all);
    repeat (pushes) line_buf.push_back(CH_CLOSE);
    if (close_all) begin
      repeat (pushes) begin
        line_buf.push_back(CH_OPEN);
        line_buf.push_back(CH_SLASH);
        line_buf.push_back(CH_CLOSE);
      end
    end
    emit_line();
  endtask

  task automatic add_random_lines(int upto);
    int r;
    while (random_chars < upto) begin
      r = $urandom_range(99);
      if (r < 60) add_nested_line();
      else if (r < 80) add_noise_line();
      else if (r < 90) add_overlong_line();
      else add_stack_line($urandom_range(1, 4), $urandom_range(1) != 0);
    end
  endtask

  task automatic drain();
    while (text_bytes.size() != 0 || in_valid || verdicts_due.size() != 0) @(posedge clk);
  endtask

  // Driver: advance to the next byte once the current transaction is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (text_bytes.size() != 0 &&
          !((cycles < QUIET_FROM || cycles >= QUIET_TO) && $urandom_range(99) < 11)) begin
        next_byte = text_bytes.pop_front();
        in_valid <= 1'b1;
        char_code <= next_byte.ch;
        end_of_line <= next_byte.eol;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: one long hold once traffic is flowing, none in the quiet window, random stalls otherwise.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_chars >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (cycles >= QUIET_FROM && cycles < QUIET_TO) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= $urandom_range(99) < 11;
    end
  end

  // Monitor: track accepted bytes and check each verdict.
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        track_char(char_code, end_of_line);
        accepted_chars <= accepted_chars + 1;
      end
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected verdict at cycle %0d: is_correct %0b overflow_seen %0b",
                     cycles, is_correct, overflow_seen);
        end else begin
          want = verdicts_due.pop_front();
          if (is_correct !== want.ok) note_mismatch("is_correct", want.ok, is_correct);
          if (overflow_seen !== want.ovf)
            note_mismatch("overflow_seen", want.ovf, overflow_seen);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    add_text("<a></a>");
    add_text("<br>");
    add_text("</x>");
    add_text(">");
    add_text("<<hr>");
    line_buf.push_back(8'h00);
    emit_line();
    line_buf.push_back(8'hFF);
    emit_line();
    random_chars = 0;
    add_stack_line(STACK_DEPTH, 1'b1);
    add_stack_line(STACK_DEPTH + 1, 1'b0);
    add_overlong_line();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    add_random_lines(RANDOM_CHARS / 2);
    // Pause the sender until every verdict is back.
    drain();
    add_random_lines(RANDOM_CHARS);
    drain();
    repeat (20) @(posedge clk);
    if (verdicts_due.size() != 0)
      $display("%0d verdicts never arrived", verdicts_due.size());
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/mtb_pkg.sv
rtl/mtb_stack_store.sv
rtl/mtb_ctrl.sv
rtl/markup_tag_balance_checker_unit.sv
verif/markup_tag_balance_checker_unit_test.sv
